// ===== src/hdn_pkg.sv =====
package hdn_pkg;

  localparam int STAGES = 10;

  localparam logic [13:0] FIRST_YEAR    = 14'd5751;
  localparam logic [13:0] WINDOW_BASE   = 14'd5750;
  localparam logic [13:0] EPOCH_OFFSET  = 14'd3744;
  localparam logic [7:0]  WINDOW_RESET  = 8'd88;

  localparam logic [15:0] RECIP_19      = 16'd55189;     // ceil(2^20 / 19)
  localparam logic [15:0] PARTS_MONTH   = 16'd39673;
  localparam logic [10:0] MOLAD_BASE    = 11'd1859;      // 1h 779p
  localparam logic [25:0] RECIP_405     = 26'd42419431;  // ceil(2^34 / 405)
  localparam logic [14:0] PARTS_DAY     = 15'd25920;
  localparam logic [16:0] RECIP_7       = 17'd74899;     // ceil(2^19 / 7)
  localparam logic [14:0] LATE_PARTS    = 15'd19440;     // 18h
  localparam logic [14:0] GATARAD_PARTS = 15'd9924;      // 9h 204p
  localparam logic [14:0] BETU_PARTS    = 15'd16789;     // 15h 589p
  localparam logic [19:0] BASE_SHIFT    = 20'd732774;

  localparam logic [9:0]  YEAR_DEFICIENT = 10'd353;
  localparam logic [9:0]  YEAR_COMPLETE  = 10'd355;
  localparam logic [9:0]  ADAR_A_DAYS    = 10'd30;

  localparam logic [3:0]  MONTH_HESHVAN = 4'd1;
  localparam logic [3:0]  MONTH_KISLEV  = 4'd2;
  localparam logic [3:0]  MONTH_ADAR_A  = 4'd5;

  typedef struct packed {
    logic [3:0] month;
    logic [4:0] day;
    logic       in_range;
  } hdn_tag_t;

  // days before month m with Heshvan 29, Kislev 30, Adar A 0
  function automatic logic [8:0] month_prefix(input logic [3:0] m);
    logic [8:0] p;
    unique case (m)
      4'd0:    p = 9'd0;
      4'd1:    p = 9'd30;
      4'd2:    p = 9'd59;
      4'd3:    p = 9'd89;
      4'd4:    p = 9'd118;
      4'd5:    p = 9'd148;
      4'd6:    p = 9'd148;
      4'd7:    p = 9'd177;
      4'd8:    p = 9'd207;
      4'd9:    p = 9'd236;
      4'd10:   p = 9'd266;
      4'd11:   p = 9'd295;
      4'd12:   p = 9'd325;
      default: p = 9'd354;
    endcase
    return p;
  endfunction

endpackage

// ===== src/hdn_ctl.sv =====
module hdn_ctl import hdn_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [STAGES-1:0] en
);

  logic [STAGES-1:0] vld;
  logic [STAGES-1:0] rdy;

  always_comb begin
    rdy[STAGES-1] = !vld[STAGES-1] || out_ready;
    for (int k = STAGES - 2; k >= 0; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) begin
        vld[0] <= in_valid;
      end
      for (int k = 1; k < STAGES; k++) begin
        if (rdy[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  assign en        = rdy;
  assign in_ready  = rdy[0];
  assign out_valid = vld[STAGES-1];

endmodule

// ===== src/hdn_rh.sv =====
module hdn_rh import hdn_pkg::*; (
  input  logic        clk,
  input  logic [5:0]  en,
  input  logic [11:0] year,
  output logic [20:0] rh_day
);

  // stage A: leap count and its quotient by 19
  logic [14:0] leaps_c;
  logic [30:0] q19_prod;
  logic [11:0] year_a;
  logic [14:0] leaps_a;
  logic [10:0] q19_a;

  assign leaps_c  = 15'(year) * 15'd7 + 15'd1;
  assign q19_prod = 31'(leaps_c) * 31'(RECIP_19);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      year_a  <= year;
      leaps_a <= leaps_c;
      q19_a   <= q19_prod[30:20];
    end
  end

  // stage B: months since epoch, position in the 19-year cycle
  logic [14:0] r19_full;
  logic [15:0] months_b;
  logic [4:0]  r19_b;

  assign r19_full = leaps_a - 15'(q19_a) * 15'd19;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      months_b <= 16'(year_a) * 16'd12 + 16'(q19_a);
      r19_b    <= r19_full[4:0];
    end
  end

  // stage C: molad in parts
  logic [31:0] parts_c;
  logic [15:0] months_c;
  logic [4:0]  r19_c;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      parts_c  <= 32'(months_b) * 32'(PARTS_MONTH) + 32'(MOLAD_BASE);
      months_c <= months_b;
      r19_c    <= r19_b;
    end
  end

  // stage D: whole days in the molad, parts / 25920 = (parts >> 6) / 405
  logic [51:0] pd_prod;
  logic [15:0] pd_d;
  logic [31:0] parts_d;
  logic [15:0] months_d;
  logic [4:0]  r19_d;

  assign pd_prod = 52'(parts_c[31:6]) * 52'(RECIP_405);

  always_ff @(posedge clk) begin
    if (en[3]) begin
      pd_d     <= pd_prod[49:34];
      parts_d  <= parts_c;
      months_d <= months_c;
      r19_d    <= r19_c;
    end
  end

  // stage E: parts within the day, weekday quotient, raw day count
  logic [31:0] rem_full;
  logic [32:0] q7_prod;
  logic [14:0] rem_e;
  logic [13:0] q7_e;
  logic [15:0] pd_e;
  logic [20:0] days_e;
  logic [4:0]  r19_e;

  assign rem_full = parts_d - 32'(pd_d) * 32'(PARTS_DAY);
  assign q7_prod  = 33'(pd_d) * 33'(RECIP_7);

  always_ff @(posedge clk) begin
    if (en[4]) begin
      rem_e  <= rem_full[14:0];
      q7_e   <= q7_prod[32:19];
      pd_e   <= pd_d;
      days_e <= 21'(months_d) * 21'd28 + 21'(pd_d) - 21'd2;
      r19_e  <= r19_d;
    end
  end

  // stage F: postponements
  logic [15:0] dow_full;
  logic [2:0]  dow;
  logic        late;
  logic [3:0]  dow_late;
  logic        adu;

  assign dow_full = pd_e - 16'(q7_e) * 16'd7;
  assign dow      = dow_full[2:0];
  assign late     = (rem_e >= LATE_PARTS) ||
                    (r19_e < 5'd12 && dow == 3'd3 && rem_e >= GATARAD_PARTS) ||
                    (r19_e < 5'd7 && dow == 3'd2 && rem_e >= BETU_PARTS);
  assign dow_late = 4'(dow) + 4'(late);
  assign adu      = (dow_late == 4'd1) || (dow_late == 4'd4) || (dow_late == 4'd6);

  always_ff @(posedge clk) begin
    if (en[5]) begin
      rh_day <= days_e + 21'(late) + 21'(adu);
    end
  end

endmodule

// ===== src/hdn_len.sv =====
module hdn_len import hdn_pkg::*; (
  input  logic        clk,
  input  logic [2:0]  en,
  input  logic [20:0] rh_this,
  input  logic [20:0] rh_next,
  input  hdn_tag_t    tag,
  output logic [15:0] day_number,
  output logic        in_range
);

  // stage G: year length and offset from base
  logic signed [21:0] base_g;
  logic [9:0]         ylen_g;
  logic [20:0]        ylen_full;
  hdn_tag_t           tag_g;

  assign ylen_full = rh_next - rh_this;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      base_g <= signed'(22'(rh_this) - 22'(BASE_SHIFT));
      ylen_g <= ylen_full[9:0];
      tag_g  <= tag;
    end
  end

  // stage H: days into the year
  logic               leap;
  logic [9:0]         ylen_plain;
  logic               deficient;
  logic               complete;
  logic [8:0]         prefix;
  logic signed [10:0] offset_h;
  logic signed [21:0] base_h;
  logic               inr_h;

  assign leap       = ylen_g > YEAR_COMPLETE;
  assign ylen_plain = leap ? ylen_g - ADAR_A_DAYS : ylen_g;
  assign deficient  = ylen_plain == YEAR_DEFICIENT;
  assign complete   = ylen_plain == YEAR_COMPLETE;
  assign prefix     = month_prefix(tag_g.month)
                    + 9'(complete && tag_g.month > MONTH_HESHVAN)
                    + ((leap && tag_g.month > MONTH_ADAR_A) ? 9'(ADAR_A_DAYS) : 9'd0)
                    - 9'(deficient && tag_g.month > MONTH_KISLEV);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      offset_h <= signed'(11'(prefix) + 11'(tag_g.day) - 11'd1);
      base_h   <= base_g;
      inr_h    <= tag_g.in_range;
    end
  end

  // stage I: sum and clamp; zero for out-of-range items
  logic signed [22:0] total;

  assign total = 23'(base_h) + 23'(offset_h);

  always_ff @(posedge clk) begin
    if (en[2]) begin
      in_range <= inr_h;
      if (!inr_h || total < 0) begin
        day_number <= 16'd0;
      end else if (total > 23'sd65535) begin
        day_number <= 16'hFFFF;
      end else begin
        day_number <= total[15:0];
      end
    end
  end

endmodule

// ===== src/hebrew_date_to_day_number_unit.sv =====
// channel | dir | signals                          | item
// s       | in  | s_tvalid s_tready s_tdata[23:0] | hebrew date
// m       | out | m_tvalid m_tready m_tdata m_tuser| day number, in-range flag
// cfg     | in  | cfg_valid cfg_ready cfg_data     | year_window write
//
// One item per cycle while m_tready is high, through a 10-stage pipeline;
// every stage moves whenever it is empty or the stage after it moves.
// Each stage holds only while it is full and the stage after it is blocked,
// so bubbles close up under m_tready stalls.
// rst clears the stage valid bits and sets year_window to 88.
// cfg_ready is always high.
module hebrew_date_to_day_number_unit import hdn_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // hebrew_year[13:0], month_index[17:14], day_of_month[22:18]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // day_number[15:0]
  output logic        m_tuser,   // in_range[0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);

  logic [7:0]        year_window;
  logic [STAGES-1:0] en;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      year_window <= WINDOW_RESET;
    end else if (cfg_valid) begin
      year_window <= cfg_data;
    end
  end

  hdn_ctl u_ctl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .en        (en)
  );

  // input stage
  logic [13:0] hebrew_year;
  logic [13:0] year_rel;
  logic [11:0] year_this;
  logic [11:0] year_next;
  hdn_tag_t    tag_d [0:6];

  assign hebrew_year = s_tdata[13:0];
  assign year_rel    = hebrew_year - EPOCH_OFFSET;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      year_this         <= year_rel[11:0];
      year_next         <= year_rel[11:0] + 12'd1;
      tag_d[0].month    <= s_tdata[17:14];
      tag_d[0].day      <= s_tdata[22:18];
      tag_d[0].in_range <= (hebrew_year >= FIRST_YEAR) &&
                           (hebrew_year <= WINDOW_BASE + 14'(year_window));
    end
  end

  for (genvar k = 1; k <= 6; k++) begin : g_tag
    always_ff @(posedge clk) begin
      if (en[k]) begin
        tag_d[k] <= tag_d[k-1];
      end
    end
  end

  logic [20:0] rh_this;
  logic [20:0] rh_next;

  hdn_rh u_rh_this (
    .clk    (clk),
    .en     (en[6:1]),
    .year   (year_this),
    .rh_day (rh_this)
  );

  hdn_rh u_rh_next (
    .clk    (clk),
    .en     (en[6:1]),
    .year   (year_next),
    .rh_day (rh_next)
  );

  hdn_len u_len (
    .clk        (clk),
    .en         (en[9:7]),
    .rh_this    (rh_this),
    .rh_next    (rh_next),
    .tag        (tag_d[6]),
    .day_number (m_tdata),
    .in_range   (m_tuser)
  );

endmodule

// ===== src/hdn_chk.sv =====
module hdn_chk (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic        m_tuser,
  input logic        cfg_ready
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("output item changed while stalled");

  a_out_of_range_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata == 16'd0)
    else $error("out-of-range item with nonzero day number");

  a_empty_takes_input: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input blocked with no output pending");

  a_flush_on_reset: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid && cfg_ready)
    else $error("pipeline not empty after reset");

endmodule

bind hebrew_date_to_day_number_unit hdn_chk u_chk (
  .clk       (clk),
  .rst       (rst),
  .s_tready  (s_tready),
  .m_tvalid  (m_tvalid),
  .m_tready  (m_tready),
  .m_tdata   (m_tdata),
  .m_tuser   (m_tuser),
  .cfg_ready (cfg_ready)
);
